// ===== hw/rtl/p2fb_pkg.sv =====
// Shared types, codes and defaults for the packed 2bpp framebuffer draw core.
package p2fb_pkg;

  localparam int DefDisplayWidth  = 400;
  localparam int DefDisplayHeight = 300;
  localparam int DefStoreBytes    = 30000;

  localparam logic [7:0] WhiteByte = 8'h55;

  typedef enum logic [2:0] {
    OP_SET_PIXEL    = 3'd0,
    OP_FILL_ALL     = 3'd1,
    OP_FILL_RECT    = 3'd2,
    OP_SPRITE_START = 3'd3,
    OP_SPRITE_BYTE  = 3'd4,
    OP_READ_BYTE    = 3'd5
  } opcode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_PRD,
    S_PWR,
    S_SPR,
    S_RDW,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_SINGLE,
    MODE_RECT,
    MODE_SPRITE
  } mode_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [14:0]        width_px;
    logic [14:0]        height_px;
    logic [1:0]         colour_code;
    logic [7:0]         sprite_byte;
    logic [14:0]        read_index;
  } draw_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       sprite_done;
  } draw_out_t;

endpackage

// ===== hw/rtl/packed_2bpp_framebuffer_draw_core.sv =====
// Packed 2bpp framebuffer draw core: command sequencer around one frame store.
//
// Command items enter on in_valid/in_ready, one result item per command leaves on
// out_valid/out_ready. Commands run one at a time; in_ready is high only while
// the core is idle. The result sits in an output register, so a new command is
// taken while an earlier result still waits for out_ready.
// Every pixel write is a read-modify-write of one store byte through the single
// memory: a read (S_PRD), then a write back (S_PWR).
//   set pixel : read (S_PRD), write back (S_PWR), then S_DONE loads the output register
//   fill rect : a read and a write back for each covered on-screen pixel
//   fill all  : sweeps the whole store, one byte written per cycle
//   sprite    : S_SPR checks each slot of the byte; each drawn pixel takes S_PRD, S_PWR
//   read byte : store read issued on accept, data captured in S_RDW
// After reset the core sweeps the store to white, one byte a cycle, over all
// StoreBytes bytes; in_ready stays low during the sweep.
// A stalled receiver holds the result; the core may take one more command but
// will not finish it until the output register is free.
module packed_2bpp_framebuffer_draw_core
  import p2fb_pkg::*;
#(
  parameter int DisplayWidth  = DefDisplayWidth,
  parameter int DisplayHeight = DefDisplayHeight,
  parameter int StoreBytes    = DefStoreBytes
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  draw_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output draw_out_t out_data
);

  localparam int XW = $clog2(DisplayWidth);
  localparam int YW = (DisplayHeight > 1) ? $clog2(DisplayHeight) : 1;
  localparam int LW = $clog2(DisplayWidth * DisplayHeight);
  localparam int AW = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;

  state_t state, state_next;

  // frame store
  logic [7:0]    mem [StoreBytes];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [7:0]    mem_q;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  // sweep
  logic [AW-1:0] cnt;
  logic [7:0]    fill_val;
  logic          cnt_last;

  // plot registers
  logic signed [17:0] px, py;
  logic [1:0]         pcol;
  logic               p_ok;
  logic [AW-1:0]      p_addr;
  logic [1:0]         p_lane;
  mode_t              mode;

  // rectangle bounds
  logic signed [17:0] rx0, rx1, ry1;

  // sprite state
  logic signed [15:0] ox, oy;
  logic [14:0]        sw, sh, srow;
  logic [13:0]        bc;
  logic [2:0]         k;
  logic [7:0]         sbyte;

  logic [7:0] res_data;
  logic       res_done;

  logic accept, out_load, out_free;

  // decode of the incoming item
  logic signed [17:0] ix, iy, ix0, iy0, ix1, iy1;
  logic               rect_nonempty, spr_active, rd_in_range;

  always_comb begin
    ix  = 18'(in_data.x_pos);
    iy  = 18'(in_data.y_pos);
    ix0 = (ix < 0) ? '0 : ix;
    iy0 = (iy < 0) ? '0 : iy;
    ix1 = ix + 18'(in_data.width_px);
    iy1 = iy + 18'(in_data.height_px);
    if (ix1 > 18'(DisplayWidth))  ix1 = 18'(DisplayWidth);
    if (iy1 > 18'(DisplayHeight)) iy1 = 18'(DisplayHeight);
    rect_nonempty = (ix0 < ix1) && (iy0 < iy1);
    spr_active    = (sw != '0) && (srow < sh);
    rd_in_range   = 32'(in_data.read_index) < 32'(StoreBytes);
  end

  // pixel address
  logic          pix_in;
  logic [LW-1:0] lin;
  logic          pix_ok;

  always_comb begin
    pix_in = (px >= 0) && (px < 18'(DisplayWidth)) && (py >= 0) && (py < 18'(DisplayHeight));
    lin    = LW'(LW'(py[YW-1:0]) * LW'(DisplayWidth)) + LW'(px[XW-1:0]);
    pix_ok = pix_in && (32'(lin >> 2) < 32'(StoreBytes));
  end

  // sprite slot
  logic [15:0] col;
  logic        slot_draw;
  logic [1:0]  slot_code;

  always_comb begin
    col       = {bc, 2'b00} + 16'(k);
    slot_draw = (k != 3'd4) && (col < 16'(sw));
    case (k[1:0])
      2'd0:    slot_code = sbyte[7:6];
      2'd1:    slot_code = sbyte[5:4];
      2'd2:    slot_code = sbyte[3:2];
      default: slot_code = sbyte[1:0];
    endcase
  end

  // byte with one pixel replaced
  logic [7:0] mod_byte;

  always_comb begin
    mod_byte = mem_q;
    case (p_lane)
      2'd0:    mod_byte[7:6] = pcol;
      2'd1:    mod_byte[5:4] = pcol;
      2'd2:    mod_byte[3:2] = pcol;
      default: mod_byte[1:0] = pcol;
    endcase
  end

  assign cnt_last = (cnt == AW'(StoreBytes - 1));
  assign out_free = !out_valid || out_ready;

  // rectangle stepping
  logic rect_row_end, rect_last;
  assign rect_row_end = (px + 18'sd1) == rx1;
  assign rect_last    = rect_row_end && ((py + 18'sd1) == ry1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (cnt_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.opcode)
            OP_SET_PIXEL:   state_next = S_PRD;
            OP_FILL_ALL:    state_next = S_FILL;
            OP_FILL_RECT:   state_next = rect_nonempty ? S_PRD : S_DONE;
            OP_SPRITE_BYTE: state_next = spr_active ? S_SPR : S_DONE;
            OP_READ_BYTE:   state_next = rd_in_range ? S_RDW : S_DONE;
            default:        state_next = S_DONE;
          endcase
        end
      end
      S_FILL: if (cnt_last) state_next = S_DONE;
      S_PRD:  state_next = S_PWR;
      S_PWR: begin
        unique case (mode)
          MODE_RECT:   state_next = rect_last ? S_DONE : S_PRD;
          MODE_SPRITE: state_next = S_SPR;
          default:     state_next = S_DONE;
        endcase
      end
      S_SPR:  state_next = slot_draw ? S_PRD : S_DONE;
      S_RDW:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_ready = (state == S_IDLE);
    out_load = (state == S_DONE) && out_free;
    mem_we   = 1'b0;
    mem_wa   = cnt;
    mem_wd   = fill_val;
    mem_re   = 1'b0;
    mem_ra   = AW'(in_data.read_index);
    unique case (state)
      S_CLEAR, S_FILL: mem_we = 1'b1;
      S_IDLE: mem_re = in_valid && (in_data.opcode == OP_READ_BYTE) && rd_in_range;
      S_PRD: begin
        mem_re = pix_ok;
        mem_ra = AW'(lin >> 2);
      end
      S_PWR: begin
        mem_we = p_ok;
        mem_wa = p_addr;
        mem_wd = mod_byte;
      end
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      fill_val <= WhiteByte;
      ox       <= '0;
      oy       <= '0;
      sw       <= '0;
      sh       <= '0;
      srow     <= '0;
      bc       <= '0;
      mode     <= MODE_SINGLE;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR, S_FILL: cnt <= cnt + AW'(1);
        S_IDLE: begin
          if (accept) begin
            res_data <= '0;
            res_done <= 1'b0;
            pcol     <= in_data.colour_code;
            unique case (in_data.opcode)
              OP_SET_PIXEL: begin
                mode <= MODE_SINGLE;
                px   <= ix;
                py   <= iy;
              end
              OP_FILL_ALL: begin
                cnt      <= '0;
                fill_val <= {4{in_data.colour_code}};
              end
              OP_FILL_RECT: begin
                mode <= MODE_RECT;
                px   <= ix0;
                py   <= iy0;
                rx0  <= ix0;
                rx1  <= ix1;
                ry1  <= iy1;
              end
              OP_SPRITE_START: begin
                ox   <= in_data.x_pos;
                oy   <= in_data.y_pos;
                sw   <= in_data.width_px;
                sh   <= in_data.height_px;
                srow <= '0;
                bc   <= '0;
              end
              OP_SPRITE_BYTE: begin
                mode  <= MODE_SPRITE;
                k     <= '0;
                sbyte <= in_data.sprite_byte;
              end
              default: ;
            endcase
          end
        end
        S_PRD: begin
          p_ok   <= pix_ok;
          p_addr <= AW'(lin >> 2);
          p_lane <= px[1:0];
        end
        S_PWR: begin
          if (mode == MODE_RECT && !rect_last) begin
            if (rect_row_end) begin
              px <= rx0;
              py <= py + 18'sd1;
            end else begin
              px <= px + 18'sd1;
            end
          end
          if (mode == MODE_SPRITE) k <= k + 3'd1;
        end
        S_SPR: begin
          if (slot_draw) begin
            px   <= 18'(ox) + 18'(col);
            py   <= 18'(oy) + 18'(srow);
            pcol <= slot_code;
          end else if (16'(bc) + 16'd1 >= 16'((16'(sw) + 16'd3) >> 2)) begin
            bc   <= '0;
            srow <= srow + 15'd1;
            if (16'(srow) + 16'd1 >= 16'(sh)) res_done <= 1'b1;
          end else begin
            bc <= bc + 14'd1;
          end
        end
        S_RDW: res_data <= mem_q;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.read_data   <= res_data;
      out_data.sprite_done <= res_done;
    end
  end

endmodule

// ===== hw/rtl/p2fb_checker.sv =====
// Port-level checks for the packed 2bpp framebuffer draw core, bound to the top level.
module p2fb_checker
  import p2fb_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input draw_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input draw_out_t out_data
);

  // reset starts the store sweep: nothing in or out right after it
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("core not quiet after reset");

  // one command in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // a sprite completion never carries read data
  a_done_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sprite_done |-> out_data.read_data == 8'h00)
    else $error("sprite_done with nonzero read_data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind packed_2bpp_framebuffer_draw_core p2fb_checker u_p2fb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the packed 2bpp framebuffer draw core.
module tb;
  import p2fb_pkg::*;

  localparam int DispW = DefDisplayWidth;
  localparam int DispH = DefDisplayHeight;
  localparam int NBytes = DefStoreBytes;
  localparam int WatchLimit = 800000;
  localparam int RandItems = 1600;

  typedef struct {
    draw_in_t  cmd;
    bit        typed;
    draw_out_t val;
  } row_t;

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  draw_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  draw_out_t out_data;

  packed_2bpp_framebuffer_draw_core i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor state
  logic [7:0] pix_store [NBytes];
  int spr_x, spr_y, spr_w, spr_h, spr_row, spr_col;
  draw_out_t result_q[$];
  int errors = 0;
  int n_sent = 0, n_done = 0, n_sprites = 0, n_fills = 0;
  bit calm = 0;
  int idle_cnt = 0;

  function automatic draw_in_t mk(opcode_t op, int x, int y, int w, int h, int c, int b,
                                  int r);
    draw_in_t d;
    d.opcode = op; d.x_pos = 16'(x); d.y_pos = 16'(y); d.width_px = 15'(w);
    d.height_px = 15'(h); d.colour_code = 2'(c); d.sprite_byte = 8'(b);
    d.read_index = 15'(r);
    return d;
  endfunction

  function automatic void plot(int x, int y, logic [1:0] code);
    int idx, sh;
    if (x < 0 || x >= DispW || y < 0 || y >= DispH) return;
    idx = (y * DispW + x) / 4;
    if (idx >= NBytes) return;
    sh = (3 - (x % 4)) * 2;
    pix_store[idx][sh +: 2] = code;
  endfunction

  function automatic draw_out_t draw_step(draw_in_t c);
    draw_out_t o;
    int x, y, x0, y0, x1, y1, col;
    o = '0;
    x = int'(c.x_pos);
    y = int'(c.y_pos);
    case (c.opcode)
      OP_SET_PIXEL: plot(x, y, c.colour_code);
      OP_FILL_ALL: begin
        foreach (pix_store[i]) pix_store[i] = {4{c.colour_code}};
      end
      OP_FILL_RECT: begin
        x0 = x < 0 ? 0 : x;
        y0 = y < 0 ? 0 : y;
        x1 = x + int'(c.width_px);
        y1 = y + int'(c.height_px);
        if (x1 > DispW) x1 = DispW;
        if (y1 > DispH) y1 = DispH;
        for (int r = y0; r < y1; r++)
          for (int k = x0; k < x1; k++) plot(k, r, c.colour_code);
      end
      OP_SPRITE_START: begin
        spr_x = x; spr_y = y; spr_w = int'(c.width_px); spr_h = int'(c.height_px);
        spr_row = 0; spr_col = 0;
      end
      OP_SPRITE_BYTE: begin
        if (spr_w != 0 && spr_row < spr_h) begin
          for (int k = 0; k < 4; k++) begin
            col = spr_col * 4 + k;
            if (col < spr_w) plot(spr_x + col, spr_y + spr_row, c.sprite_byte[(3-k)*2 +: 2]);
          end
          spr_col++;
          if (spr_col >= (spr_w + 3) / 4) begin
            spr_col = 0;
            spr_row++;
            if (spr_row >= spr_h) o.sprite_done = 1'b1;
          end
        end
      end
      OP_READ_BYTE: if (c.read_index < NBytes) o.read_data = pix_store[c.read_index];
      default: ;
    endcase
    return o;
  endfunction

  function automatic int gap_draw();
    return calm ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13));
  endfunction

  task automatic send(draw_in_t c, bit typed, draw_out_t val);
    draw_out_t p;
    int g;
    g = gap_draw();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    p = draw_step(c);
    result_q.push_back(typed ? val : p);
    n_sent++;
    if (c.opcode == OP_FILL_ALL || c.opcode == OP_FILL_RECT) n_fills++;
    if (c.opcode == OP_SPRITE_START) n_sprites++;
    if (n_sent % 200 == 0) calm = ~calm;
  endtask

  // result side: per-item stall
  int stall = 0;
  int out_gap;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1;
      stall <= 0;
    end else if (out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        if (out_data.read_data !== result_q[0].read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, result_q[0].read_data,
                   out_data.read_data);
          errors++;
        end
        if (out_data.sprite_done !== result_q[0].sprite_done) begin
          $display("%0t: sprite_done expected %b actual %b", $time,
                   result_q[0].sprite_done, out_data.sprite_done);
          errors++;
        end
        void'(result_q.pop_front());
      end
      n_done++;
      out_gap = gap_draw();
      stall <= out_gap;
      out_ready <= (out_gap == 0);
    end else if (stall > 0) begin
      stall <= stall - 1;
      if (stall == 1) out_ready <= 1;
    end else begin
      out_ready <= 1;
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  row_t dir[$];

  task automatic add(draw_in_t c, bit typed = 0, int rd = 0, bit dn = 0);
    row_t r;
    r.cmd = c; r.typed = typed; r.val.read_data = 8'(rd); r.val.sprite_done = dn;
    dir.push_back(r);
  endtask

  initial begin
    draw_in_t c;
    int w, h, nb;
    foreach (pix_store[i]) pix_store[i] = WhiteByte;
    spr_x = 0; spr_y = 0; spr_w = 0; spr_h = 0; spr_row = 0; spr_col = 0;

    add(mk(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, 0), 1, WhiteByte);
    add(mk(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, NBytes - 1), 1, WhiteByte);
    add(mk(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, NBytes), 1, 0);
    add(mk(OP_READ_BYTE, -1, -1, 32767, 32767, 3, 255, 32767), 1, 0);
    add(mk(OP_SET_PIXEL, 0, 0, 0, 0, 2, 0, 0));
    add(mk(OP_SET_PIXEL, DispW - 1, DispH - 1, 0, 0, 3, 0, 0));
    add(mk(OP_SET_PIXEL, -1, 0, 0, 0, 0, 0, 0));
    add(mk(OP_SET_PIXEL, DispW, 0, 0, 0, 0, 0, 0));
    add(mk(OP_SET_PIXEL, 0, DispH, 0, 0, 0, 0, 0));
    add(mk(OP_SET_PIXEL, -32768, 32767, 0, 0, 0, 0, 0));
    add(mk(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, 0));
    add(mk(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, NBytes - 1));
    add(mk(opcode_t'(3'd6), 5, 5, 5, 5, 3, 255, 0), 1, 0);
    add(mk(opcode_t'(3'd7), 5, 5, 5, 5, 3, 255, 0), 1, 0);
    add(mk(OP_SPRITE_BYTE, 0, 0, 0, 0, 0, 8'hAA, 0), 1, 0);   // no sprite yet
    add(mk(OP_SPRITE_START, 10, 10, 0, 4, 0, 0, 0));
    add(mk(OP_SPRITE_BYTE, 0, 0, 0, 0, 0, 8'hFF, 0), 1, 0);   // zero width
    add(mk(OP_FILL_RECT, -32768, -32768, 32767, 32767, 2, 0, 0));
    add(mk(OP_FILL_RECT, DispW - 10, DispH - 10, 32767, 32767, 2, 0, 0));
    add(mk(OP_FILL_RECT, 20, 20, 0, 9, 3, 0, 0));
    add(mk(OP_FILL_ALL, 0, 0, 0, 0, 3, 0, 0));
    add(mk(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, 100), 1, 8'hFF);
    add(mk(OP_SPRITE_START, DispW - 2, DispH - 1, 5, 2, 0, 0, 0));
    add(mk(OP_SPRITE_BYTE, 0, 0, 0, 0, 0, 8'h1B, 0));
    add(mk(OP_SPRITE_START, 32760, 5, 20, 1, 0, 0, 0));       // restart, runs past range
    for (int i = 0; i < 5; i++) add(mk(OP_SPRITE_BYTE, 0, 0, 0, 0, 0, 8'h00, 0));
    add(mk(OP_SPRITE_BYTE, 0, 0, 0, 0, 0, 8'h00, 0), 1, 0);   // already done

    repeat (6) @(posedge clk);
    rst <= 0;
    foreach (dir[i]) send(dir[i].cmd, dir[i].typed, dir[i].val);

    for (int n = 0; n < RandItems; ) begin
      int pick;
      pick = $urandom_range(0, 999);
      c = mk(OP_READ_BYTE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom);
      if (pick < 3) begin
        c.opcode = OP_FILL_ALL;
      end else if (pick < 250) begin
        c.opcode = OP_SET_PIXEL;
        if (pick > 20) begin
          c.x_pos = 16'($urandom_range(0, DispW + 8) - 4);
          c.y_pos = 16'($urandom_range(0, DispH + 8) - 4);
        end
      end else if (pick < 340) begin
        c.opcode = OP_FILL_RECT;
        if (pick < 260) begin
          c.y_pos = 16'(DispH + $urandom_range(0, 1000));       // huge sizes, off-screen
        end else begin
          c.x_pos = 16'($urandom_range(0, DispW + 8) - 8);
          c.y_pos = 16'($urandom_range(0, DispH + 8) - 8);
          c.width_px = 15'($urandom_range(0, 12));
          c.height_px = 15'($urandom_range(0, 6));
        end
      end else if (pick < 650) begin
        w = (pick < 360) ? $urandom_range(0, 32767) : $urandom_range(1, 13);
        h = (pick < 360) ? $urandom_range(0, 3) : $urandom_range(1, 5);
        c.opcode = OP_SPRITE_START;
        c.x_pos = (pick < 355) ? 16'($urandom) : 16'($urandom_range(0, DispW + 16) - 8);
        c.y_pos = 16'($urandom_range(0, DispH + 10) - 5);
        c.width_px = 15'(w);
        c.height_px = 15'(h);
        send(c, 0, '0);
        n++;
        nb = (w + 3) / 4 * h;
        if (nb > 40) nb = $urandom_range(0, 40);
        if ($urandom_range(0, 9) == 0) nb = $urandom_range(0, nb + 2);  // broken sequence
        for (int k = 0; k < nb; k++) begin
          c = mk(OP_SPRITE_BYTE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom);
          send(c, 0, '0);
          n++;
        end
        continue;
      end else if (pick < 920) begin
        c.opcode = OP_READ_BYTE;
        if (pick > 900) c.read_index = 15'($urandom_range(0, 32767));
        else c.read_index = 15'($urandom_range(0, NBytes - 1));
      end else begin
        c.opcode = opcode_t'(3'($urandom_range(4, 7)));
      end
      send(c, 0, '0);
      n++;
    end
    in_valid <= 0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d items, got %0d results; %0d sprites, %0d fills, %0d errors.",
             n_sent, n_done, n_sprites, n_fills, errors);
    if (errors == 0 && result_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
